// ----- hw/rtl/selective_repeat_window_macros.svh -----
// ---------------------------------------------------------------------------
// Selective repeat window assertion macros
// Clocked, reset-qualified property shorthands for the window engine.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_WINDOW_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/srw_pkg.sv -----
// ---------------------------------------------------------------------------
// srw_pkg
// Shared types, codes and window helpers for the selective repeat engine.
// ---------------------------------------------------------------------------
package srw_pkg;

    localparam int unsigned MAX_WINDOW_DEF = 64;
    localparam int unsigned SEQ_W          = 7;
    localparam int unsigned EV_W           = 3;
    localparam int unsigned BITS_W         = 3;

    localparam logic [BITS_W-1:0] SEQ_BITS_RST = 3'd3;
    localparam logic [BITS_W-1:0] SEQ_BITS_MIN = 3'd2;

    // Event codes of a result word
    localparam logic [EV_W-1:0] EV_SKIP   = 3'd0;
    localparam logic [EV_W-1:0] EV_ACCEPT = 3'd1;
    localparam logic [EV_W-1:0] EV_DUP    = 3'd2;
    localparam logic [EV_W-1:0] EV_NAK    = 3'd3;
    localparam logic [EV_W-1:0] EV_LOST   = 3'd4;

    typedef struct packed {
        logic frame_arrives;
        logic frame_damaged;
        logic ack_lost;
    } in_word_t;

    typedef struct packed {
        logic [SEQ_W-1:0] slot_seq;
        logic             was_sent;
        logic [EV_W-1:0]  event_code;
        logic             ack_ok;
        logic             round_end;
    } out_word_t;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic init;      // reload reset contents
        logic move;      // shift send slots one place towards the head
        logic probe;     // capture receiver match against the head sequence
        logic grant_en;  // replace the granted receiver entry
    } cell_ctl_t;

    // Send window size for a given seq_bits value, capped at max_w
    function automatic logic [7:0] window_of(input logic [BITS_W-1:0] bits,
                                             input int unsigned max_w);
        logic [BITS_W-1:0] eff;
        logic [7:0]        half;
        eff  = (bits < SEQ_BITS_MIN) ? SEQ_BITS_MIN : bits;
        half = 8'd1 << (eff - 3'd1);
        if (half > 8'(max_w)) begin
            half = 8'(max_w);
        end
        return half;
    endfunction

    // Modulus minus one for the sequence space
    function automatic logic [SEQ_W-1:0] seq_mask(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] eff;
        logic [7:0]        full;
        eff  = (bits < SEQ_BITS_MIN) ? SEQ_BITS_MIN : bits;
        full = (8'd1 << eff) - 8'd1;
        return full[SEQ_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/srw_cell.sv -----
// ---------------------------------------------------------------------------
// srw_cell
// One window position: a send slot (sequence, acked) and a receiver entry.
// ---------------------------------------------------------------------------
module srw_cell #(
    parameter int unsigned MAX_WINDOW = srw_pkg::MAX_WINDOW_DEF,
    parameter int unsigned INDEX      = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srw_pkg::cell_ctl_t              ctl,
    input  logic [$clog2(MAX_WINDOW)-1:0]   w_last,
    input  logic [srw_pkg::SEQ_W-1:0]       right_seq,
    input  logic                            right_acked,
    input  logic [srw_pkg::SEQ_W-1:0]       tail_seq,
    input  logic                            tail_acked,
    input  logic [srw_pkg::SEQ_W-1:0]       probe_seq,
    input  logic                            grant,
    input  logic [srw_pkg::SEQ_W-1:0]       recv_new,
    output logic [srw_pkg::SEQ_W-1:0]       seq,
    output logic                            acked,
    output logic                            match
);

    localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
    localparam logic [srw_pkg::SEQ_W-1:0] INIT_SEQ = srw_pkg::SEQ_W'(INDEX);

    logic [srw_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic                      acked_reg, acked_next;
    logic [srw_pkg::SEQ_W-1:0] exp_reg, exp_next;
    logic                      match_reg, match_next;
    logic                      is_tail;
    logic                      active;

    assign is_tail = (IDX_W'(INDEX) == w_last);
    assign active  = (IDX_W'(INDEX) <= w_last);

    always_comb
    begin
        seq_next   = seq_reg;
        acked_next = acked_reg;
        exp_next   = exp_reg;
        match_next = match_reg;
        if (ctl.init)
        begin
            seq_next   = INIT_SEQ;
            acked_next = 1'b0;
            exp_next   = INIT_SEQ;
        end
        else
        begin
            if (ctl.move)
            begin
                seq_next   = is_tail ? tail_seq   : right_seq;
                acked_next = is_tail ? tail_acked : right_acked;
            end
            if (ctl.probe)
            begin
                match_next = active && (exp_reg == probe_seq);
            end
            if (ctl.grant_en && grant)
            begin
                exp_next = recv_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= INIT_SEQ;
            acked_reg <= 1'b0;
            exp_reg   <= INIT_SEQ;
            match_reg <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            acked_reg <= acked_next;
            exp_reg   <= exp_next;
            match_reg <= match_next;
        end
    end

    assign seq   = seq_reg;
    assign acked = acked_reg;
    assign match = match_reg;

endmodule

// ----- hw/rtl/selective_repeat_window.sv -----
// ---------------------------------------------------------------------------
// selective_repeat_window
// Selective repeat ARQ window engine built as a ring of window cells.
// ---------------------------------------------------------------------------
// Usage:
//  in    : one word per send slot of a round, giving the channel outcome
//          (arrival, damage or loss, ack loss). valid/ready.
//  out   : one word per input word: slot sequence, sent flag, event code,
//          ack state and round-end flag. valid/ready, registered.
//  cfg   : write of seq_bits (3 bits); taken only when the engine is idle,
//          reloads both windows and all counters as reset does.
// Timing: a word is taken in an idle cycle and its receiver match is
//  captured in every cell at once; the result is registered in the update
//  state once out is free. After the last slot of a round the ring shifts
//  out the leading acked slots one per cycle before the next word is taken.
// The send window rotates through the cells so the current slot is always
//  in cell 0; the receiver entries stay in place and the first match is
//  picked by a lowest-set-bit pick over the captured match flags.
// Reset: windows hold slot indices, nothing acked, seq_bits = 3.
// Stall: a result waiting on out holds the engine in its update cycle; the
//  next input word is still taken while a previous result waits.
// ---------------------------------------------------------------------------
`include "selective_repeat_window_macros.svh"

module selective_repeat_window #(
    parameter int unsigned MAX_WINDOW = srw_pkg::MAX_WINDOW_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  srw_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output srw_pkg::out_word_t           out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [srw_pkg::BITS_W-1:0]   cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
    localparam int unsigned SEQ_W = srw_pkg::SEQ_W;
    localparam logic [7:0]  RST_W = srw_pkg::window_of(srw_pkg::SEQ_BITS_RST, MAX_WINDOW);
    localparam logic [SEQ_W-1:0] RST_NEXT = RST_W[SEQ_W-1:0];

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_UPD   = 3'b010,
        ST_SLIDE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [srw_pkg::BITS_W-1:0]   seq_bits_reg, seq_bits_next;
    logic [SEQ_W-1:0]             next_send_reg, next_send_next;
    logic [SEQ_W-1:0]             next_recv_reg, next_recv_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    srw_pkg::in_word_t            in_word_reg, in_word_next;
    srw_pkg::out_word_t           out_word_reg, out_word_next;
    logic                         out_valid_reg, out_valid_next;

    // Window geometry from the current register
    logic [7:0]                   w_cur;
    logic [IDX_W-1:0]             w_last;
    logic [SEQ_W-1:0]             mask_cur;
    logic [7:0]                   w_new;

    // Cell ring
    srw_pkg::cell_ctl_t           ctl;
    logic [SEQ_W-1:0]             cell_seq   [MAX_WINDOW];
    logic                         cell_acked [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]        match_vec;
    logic [MAX_WINDOW-1:0]        grant_vec;
    logic [SEQ_W-1:0]             tail_seq;
    logic                         tail_acked;

    // Per-word decision
    logic                         head_acked;
    logic                         any_match;
    logic                         sending;
    logic                         new_ack;
    logic [srw_pkg::EV_W-1:0]     ev;
    logic                         is_last;
    logic                         load;
    logic                         in_acc;
    logic                         cfg_acc;

    assign w_cur    = srw_pkg::window_of(seq_bits_reg, MAX_WINDOW);
    assign w_last   = IDX_W'(w_cur - 8'd1);
    assign mask_cur = srw_pkg::seq_mask(seq_bits_reg);
    assign w_new    = srw_pkg::window_of(cfg_data, MAX_WINDOW);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && in_ready;

    assign head_acked = cell_acked[0];
    assign any_match  = |match_vec;
    // lowest set bit: first matching receiver entry
    assign grant_vec  = match_vec & (~match_vec + MAX_WINDOW'(1));
    assign sending    = !head_acked;
    assign is_last    = (slot_reg == w_last);
    assign load       = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ev      = srw_pkg::EV_SKIP;
        new_ack = 1'b1;
        if (sending)
        begin
            if (in_word_reg.frame_arrives)
            begin
                ev      = any_match ? srw_pkg::EV_ACCEPT : srw_pkg::EV_DUP;
                new_ack = !in_word_reg.ack_lost;
            end
            else
            begin
                ev      = in_word_reg.frame_damaged ? srw_pkg::EV_NAK : srw_pkg::EV_LOST;
                new_ack = 1'b0;
            end
        end
    end

    // Tail feed: the processed head on a rotate, a fresh slot while sliding
    always_comb
    begin
        if (state_reg == ST_SLIDE)
        begin
            tail_seq   = next_send_reg;
            tail_acked = 1'b0;
        end
        else
        begin
            tail_seq   = cell_seq[0];
            tail_acked = new_ack;
        end
    end

    always_comb
    begin
        ctl.init     = cfg_acc;
        ctl.probe    = in_acc;
        ctl.move     = load || ((state_reg == ST_SLIDE) && head_acked);
        ctl.grant_en = load && sending && in_word_reg.frame_arrives;
    end

    generate
        for (genvar i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            logic [SEQ_W-1:0] right_seq;
            logic             right_acked;
            if (i == MAX_WINDOW - 1)
            begin : g_end
                assign right_seq   = tail_seq;
                assign right_acked = tail_acked;
            end
            else
            begin : g_mid
                assign right_seq   = cell_seq[i+1];
                assign right_acked = cell_acked[i+1];
            end
            srw_cell #(
                .MAX_WINDOW (MAX_WINDOW),
                .INDEX      (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .w_last      (w_last),
                .right_seq   (right_seq),
                .right_acked (right_acked),
                .tail_seq    (tail_seq),
                .tail_acked  (tail_acked),
                .probe_seq   (cell_seq[0]),
                .grant       (grant_vec[i]),
                .recv_new    (next_recv_reg),
                .seq         (cell_seq[i]),
                .acked       (cell_acked[i]),
                .match       (match_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        seq_bits_next  = seq_bits_reg;
        next_send_next = next_send_reg;
        next_recv_next = next_recv_reg;
        slot_next      = slot_reg;
        in_word_next   = in_word_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    seq_bits_next  = cfg_data;
                    next_send_next = w_new[SEQ_W-1:0];
                    next_recv_next = w_new[SEQ_W-1:0];
                    slot_next      = '0;
                end
                else if (in_acc)
                begin
                    in_word_next = in_data;
                    state_next   = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (load)
                begin
                    out_word_next.slot_seq   = cell_seq[0];
                    out_word_next.was_sent   = sending;
                    out_word_next.event_code = ev;
                    out_word_next.ack_ok     = new_ack;
                    out_word_next.round_end  = is_last;
                    out_valid_next           = 1'b1;
                    if (ctl.grant_en && any_match)
                    begin
                        next_recv_next = (next_recv_reg + 1'b1) & mask_cur;
                    end
                    if (is_last)
                    begin
                        slot_next  = '0;
                        state_next = ST_SLIDE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SLIDE:
            begin
                if (head_acked)
                begin
                    next_send_next = (next_send_reg + 1'b1) & mask_cur;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_bits_reg  <= srw_pkg::SEQ_BITS_RST;
            next_send_reg <= RST_NEXT;
            next_recv_reg <= RST_NEXT;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_bits_reg  <= seq_bits_next;
            next_send_reg <= next_send_next;
            next_recv_reg <= next_recv_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Assertions
    `SRW_ASSERT_NOW(a_grant_onehot, 1'b1, $onehot0(grant_vec),
        "more than one receiver entry granted")
    `SRW_ASSERT_NOW(a_slot_in_window, 1'b1, slot_reg <= w_last,
        "slot counter beyond window")
    `SRW_ASSERT_NEXT(a_round_slides, load && is_last, state_reg == ST_SLIDE,
        "round end did not start the slide")
    `SRW_ASSERT_NEXT(a_slide_ends_unacked, (state_reg == ST_SLIDE) && !head_acked,
        state_reg == ST_IDLE, "slide did not stop at an unacked head")

endmodule
